[src/wbf_pkg.sv]
// Shared types and constants for the write buffer FIFO.
`timescale 1ns / 1ps

package wbf_pkg;

  // Fixed field widths of the item and result channels
  localparam int ADDR_W      = 32;
  localparam int IN_DATA_W   = 64;
  localparam int COUNT_W     = 4;
  localparam int IN_MAX_BYTES = 8;

  // Configuration port
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BYTES    = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_ENTRIES_RESET  = 4'd8;
  localparam logic [CFG_W-1:0]     CFG_BYTES_RESET    = 4'd8;

  // Default sizes of the ring
  localparam int DEF_RING_DEPTH      = 8;
  localparam int DEF_MAX_ENTRY_BYTES = 8;

  // Small two-slot queues between the parts
  localparam int Q_DEPTH = 2;
  localparam int Q_IDX_W = 1;
  localparam int Q_CNT_W = 2;

  // Opcodes of the input channel
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_DRAIN = 1'b1
  } item_kind_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    item_kind_t             kind;
    logic [ADDR_W-1:0]      addr;
    logic [IN_DATA_W-1:0]   data;
    logic [COUNT_W-1:0]     count;
  } item_t;

  // One memory byte write
  typedef struct packed {
    logic [ADDR_W-1:0] mem_address;
    logic [7:0]        mem_byte;
    logic              last_of_run;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_EMIT,
    ST_STORE,
    ST_FINISH
  } back_state_t;

endpackage

[src/write_buffer_fifo.sv]
// Top level of the write buffer FIFO: configuration registers and part wiring.
`timescale 1ns / 1ps

// Channel   Ports                                          Transfer when
// input     in_push, in_full, in_opcode, in_address,       in_push && !in_full
//           in_data_bytes, in_byte_count
// result    out_empty, out_pop, out_mem_address,           out_pop && !out_empty
//           out_mem_byte, out_last_of_run
// config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid && cfg_ready
//
// The back sequencer works on one item at a time. A write is split into chunks,
// each stored in the ring after the oldest entry is evicted if the ring is full;
// a drain emits every held entry (one byte per cycle unless the emitter stalls).
// Two-slot queues on input and result let each side stall on its own; a full
// result queue holds the byte emitter. Synchronous reset empties the ring and
// both queues; entry contents are not cleared. cfg_ready is always high.

module write_buffer_fifo #(
  parameter int RING_DEPTH      = wbf_pkg::DEF_RING_DEPTH,
  parameter int MAX_ENTRY_BYTES = wbf_pkg::DEF_MAX_ENTRY_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_opcode,
  input  logic [wbf_pkg::ADDR_W-1:0]    in_address,
  input  logic [wbf_pkg::IN_DATA_W-1:0] in_data_bytes,
  input  logic [wbf_pkg::COUNT_W-1:0]   in_byte_count,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [wbf_pkg::ADDR_W-1:0]    out_mem_address,
  output logic [7:0]                    out_mem_byte,
  output logic                          out_last_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wbf_pkg::CFG_W-1:0]     cfg_data
);
  import wbf_pkg::*;

  localparam int OCC_W = $clog2(RING_DEPTH + 1);
  localparam int LEN_W = $clog2(MAX_ENTRY_BYTES + 1);

  logic [CFG_W-1:0] entries_r;
  logic [CFG_W-1:0] bytes_r;
  logic [OCC_W-1:0] ring_size;
  logic [LEN_W-1:0] chunk_limit;
  logic             item_valid;
  item_t            item;
  logic             item_pop;
  logic             oq_full;
  logic             oq_push;
  result_t          oq_item;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= CFG_ENTRIES_RESET;
      bytes_r   <= CFG_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENTRIES_IN_USE: entries_r <= cfg_data;
        CFG_ENTRY_BYTES:    bytes_r   <= cfg_data;
        default:            entries_r <= entries_r;
      endcase
    end
  end

  // Clamp register values to the built ring
  always_comb begin
    if (entries_r == '0) begin
      ring_size = OCC_W'(1);
    end else if (entries_r > CFG_W'(RING_DEPTH)) begin
      ring_size = OCC_W'(RING_DEPTH);
    end else begin
      ring_size = OCC_W'(entries_r);
    end
    if (bytes_r == '0) begin
      chunk_limit = LEN_W'(1);
    end else if (bytes_r > CFG_W'(MAX_ENTRY_BYTES)) begin
      chunk_limit = LEN_W'(MAX_ENTRY_BYTES);
    end else begin
      chunk_limit = LEN_W'(bytes_r);
    end
  end

  wbf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_address    (in_address),
    .in_data_bytes (in_data_bytes),
    .in_byte_count (in_byte_count),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop)
  );

  wbf_back #(
    .RING_DEPTH      (RING_DEPTH),
    .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ring_size   (ring_size),
    .chunk_limit (chunk_limit),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop),
    .oq_full     (oq_full),
    .oq_push     (oq_push),
    .oq_item     (oq_item)
  );

  wbf_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .oq_push         (oq_push),
    .oq_item         (oq_item),
    .oq_full         (oq_full),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_mem_address (out_mem_address),
    .out_mem_byte    (out_mem_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[src/wbf_front.sv]
// Front part: accepts items, classifies them and queues them for the back.
`timescale 1ns / 1ps

module wbf_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_opcode,
  input  logic [wbf_pkg::ADDR_W-1:0]    in_address,
  input  logic [wbf_pkg::IN_DATA_W-1:0] in_data_bytes,
  input  logic [wbf_pkg::COUNT_W-1:0]   in_byte_count,
  output logic                          item_valid,
  output wbf_pkg::item_t                item,
  input  logic                          item_pop
);
  import wbf_pkg::*;

  item_t              slot_r [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [Q_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  item_t              cls;
  logic               keep;
  logic               do_push;
  logic               do_pop;

  // Classify: clamp the byte count, drop writes that carry no bytes
  always_comb begin
    cls.kind  = (in_opcode == OP_DRAIN) ? KIND_DRAIN : KIND_WRITE;
    cls.addr  = in_address;
    cls.data  = in_data_bytes;
    cls.count = (in_byte_count > COUNT_W'(IN_MAX_BYTES)) ? COUNT_W'(IN_MAX_BYTES)
                                                         : in_byte_count;
    keep      = (cls.kind == KIND_DRAIN) || (in_byte_count != '0);
  end

  assign in_full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = slot_r[rd_idx_r];
  assign do_push    = in_push && !in_full && keep;
  assign do_pop     = item_pop && item_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_idx_nxt = do_push ? wr_idx_r + 1'b1 : wr_idx_r;
    rd_idx_nxt = do_pop ? rd_idx_r + 1'b1 : rd_idx_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued items
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_idx_r] <= cls;
    end
  end

endmodule

[src/wbf_outq.sv]
// Result queue: holds memory byte writes until the consumer takes them.
`timescale 1ns / 1ps

module wbf_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       oq_push,
  input  wbf_pkg::result_t           oq_item,
  output logic                       oq_full,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [wbf_pkg::ADDR_W-1:0] out_mem_address,
  output logic [7:0]                 out_mem_byte,
  output logic                       out_last_of_run
);
  import wbf_pkg::*;

  result_t            slot_r [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [Q_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  result_t            head;
  logic               do_push;
  logic               do_pop;

  assign oq_full         = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign out_empty       = (cnt_r == '0);
  assign head            = slot_r[rd_idx_r];
  assign out_mem_address = head.mem_address;
  assign out_mem_byte    = head.mem_byte;
  assign out_last_of_run = head.last_of_run;
  assign do_push         = oq_push && !oq_full;
  assign do_pop          = out_pop && !out_empty;

  // Advance pointers and fill count
  always_comb begin
    wr_idx_nxt = do_push ? wr_idx_r + 1'b1 : wr_idx_r;
    rd_idx_nxt = do_pop ? rd_idx_r + 1'b1 : rd_idx_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued results
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_idx_r] <= oq_item;
    end
  end

endmodule

[src/wbf_back.sv]
// Back part: entry ring, chunking of writes, eviction and drain sequencer.
`timescale 1ns / 1ps

module wbf_back #(
  parameter int RING_DEPTH      = wbf_pkg::DEF_RING_DEPTH,
  parameter int MAX_ENTRY_BYTES = wbf_pkg::DEF_MAX_ENTRY_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [$clog2(RING_DEPTH+1)-1:0]      ring_size,
  input  logic [$clog2(MAX_ENTRY_BYTES+1)-1:0] chunk_limit,
  input  logic                                 item_valid,
  input  wbf_pkg::item_t                       item,
  output logic                                 item_pop,
  input  logic                                 oq_full,
  output logic                                 oq_push,
  output wbf_pkg::result_t                     oq_item
);
  import wbf_pkg::*;

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int OCC_W = $clog2(RING_DEPTH + 1);
  localparam int LEN_W = $clog2(MAX_ENTRY_BYTES + 1);
  localparam int E_W   = 8 * MAX_ENTRY_BYTES;

  back_state_t state_r, state_nxt;

  // Ring storage
  logic [ADDR_W-1:0] mem_addr [RING_DEPTH];
  logic [E_W-1:0]    mem_data [RING_DEPTH];
  logic [LEN_W-1:0]  mem_len  [RING_DEPTH];
  logic [ADDR_W-1:0] rd_addr_r;
  logic [E_W-1:0]    rd_data_r;
  logic [LEN_W-1:0]  rd_len_r;

  // Ring control
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W-1:0] wp_step, rp_step;
  logic [OCC_W-1:0] occ_r;

  // Item being worked on
  logic                 drain_r;
  logic [ADDR_W-1:0]    w_addr_r;
  logic [IN_DATA_W-1:0] w_data_r;
  logic [COUNT_W-1:0]   w_left_r;

  // Entry being emitted
  logic [ADDR_W-1:0] e_addr_r;
  logic [E_W-1:0]    e_data_r;
  logic [LEN_W-1:0]  e_cnt_r;

  // Result held back until it is known whether it ends the run
  logic              pend_v_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic [7:0]        pend_byte_r;

  logic               ring_full;
  logic [COUNT_W-1:0] limit_ext;
  logic [COUNT_W-1:0] take;
  logic [E_W-1:0]     st_data;
  logic               emit_ok;
  logic               load_entry;
  logic               emit;
  logic               release_entry;
  logic               store;
  logic               push_last;

  assign ring_full = (occ_r >= ring_size);
  assign limit_ext = COUNT_W'(chunk_limit);
  assign take      = (w_left_r < limit_ext) ? w_left_r : limit_ext;
  assign emit_ok   = !(pend_v_r && oq_full);

  // Step pointers, wrapping at the ring size
  always_comb begin
    wp_step = ((PTR_W+1)'(wp_r) + 1'b1 >= (PTR_W+1)'(ring_size)) ? '0 : wp_r + 1'b1;
    rp_step = ((PTR_W+1)'(rp_r) + 1'b1 >= (PTR_W+1)'(ring_size)) ? '0 : rp_r + 1'b1;
  end

  // Keep only the bytes of the current chunk
  always_comb begin
    for (int i = 0; i < MAX_ENTRY_BYTES; i++) begin
      st_data[8*i +: 8] = (COUNT_W'(i) < take) ? w_data_r[8*i +: 8] : 8'h00;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (drain_r) begin
          state_nxt = (occ_r != '0) ? ST_READ : ST_FINISH;
        end else if (w_left_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ring_full ? ST_READ : ST_STORE;
        end
      end
      ST_READ: begin
        if (rd_len_r == '0) begin
          state_nxt = drain_r ? ST_DECIDE : ST_STORE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok && e_cnt_r == LEN_W'(1)) begin
          state_nxt = drain_r ? ST_DECIDE : ST_STORE;
        end
      end
      ST_STORE: begin
        state_nxt = ST_DECIDE;
      end
      ST_FINISH: begin
        if (!pend_v_r || !oq_full) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control strobes
  always_comb begin
    item_pop      = 1'b0;
    load_entry    = 1'b0;
    emit          = 1'b0;
    release_entry = 1'b0;
    store         = 1'b0;
    push_last     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        item_pop = item_valid;
      end
      ST_READ: begin
        load_entry    = 1'b1;
        release_entry = (rd_len_r == '0);
      end
      ST_EMIT: begin
        emit          = emit_ok;
        release_entry = emit_ok && (e_cnt_r == LEN_W'(1));
      end
      ST_STORE: begin
        store = 1'b1;
      end
      ST_FINISH: begin
        push_last = pend_v_r && !oq_full;
      end
      default: begin
        item_pop = 1'b0;
      end
    endcase
  end

  // Pass the held result on once the next one shows up or the item ends
  assign oq_push             = (emit && pend_v_r) || push_last;
  assign oq_item.mem_address = pend_addr_r;
  assign oq_item.mem_byte    = pend_byte_r;
  assign oq_item.last_of_run = push_last;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      occ_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (store) begin
        wp_r <= wp_step;
        if (occ_r < OCC_W'(RING_DEPTH)) occ_r <= occ_r + 1'b1;
      end
      if (release_entry) begin
        rp_r <= rp_step;
        if (occ_r != '0) occ_r <= occ_r - 1'b1;
      end
      if (emit) begin
        pend_v_r <= 1'b1;
      end else if (push_last) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    if (item_pop) begin
      drain_r  <= (item.kind == KIND_DRAIN);
      w_addr_r <= item.addr;
      w_data_r <= item.data;
      w_left_r <= item.count;
    end else if (store) begin
      w_addr_r <= w_addr_r + ADDR_W'(take);
      w_data_r <= w_data_r >> {take, 3'b000};
      w_left_r <= w_left_r - take;
    end
    if (load_entry) begin
      e_addr_r <= rd_addr_r;
      e_data_r <= rd_data_r;
      e_cnt_r  <= rd_len_r;
    end else if (emit) begin
      e_addr_r <= e_addr_r + 1'b1;
      e_data_r <= e_data_r >> 8;
      e_cnt_r  <= e_cnt_r - 1'b1;
    end
    if (emit) begin
      pend_addr_r <= e_addr_r;
      pend_byte_r <= e_data_r[7:0];
    end
  end

  // Ring memory: write at the write pointer, registered read at the read pointer
  always_ff @(posedge clk) begin
    if (store) begin
      mem_addr[wp_r] <= w_addr_r;
      mem_data[wp_r] <= st_data;
      mem_len[wp_r]  <= LEN_W'(take);
    end
    rd_addr_r <= mem_addr[rp_r];
    rd_data_r <= mem_data[rp_r];
    rd_len_r  <= mem_len[rp_r];
  end

endmodule

[sim/tb_write_buffer_fifo.sv]
// Self-checking testbench for the write buffer FIFO: random and directed transfers.
`timescale 1ns / 1ps

module tb_write_buffer_fifo;
  import wbf_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RX_HOLD_LEN   = 400;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic                 in_opcode = OP_WRITE;
  logic [ADDR_W-1:0]    in_address = '0;
  logic [IN_DATA_W-1:0] in_data_bytes = '0;
  logic [COUNT_W-1:0]   in_byte_count = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [ADDR_W-1:0]    out_mem_address;
  logic [7:0]           out_mem_byte;
  logic                 out_last_of_run;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENTRIES_IN_USE;
  logic [CFG_W-1:0]     cfg_data = '0;

  write_buffer_fifo dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_address      (in_address),
    .in_data_bytes   (in_data_bytes),
    .in_byte_count   (in_byte_count),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_mem_address (out_mem_address),
    .out_mem_byte    (out_mem_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores
  item_t   pending_items[$];
  result_t expected_writes[$];
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;
  bit      tx_idle_en = 1'b1;
  bit      rx_idle_en = 1'b1;
  int      rx_hold_req = 0;

  // Shadow of the buffer: configuration, ring contents and pointers
  logic [CFG_W-1:0]     shadow_entries = CFG_ENTRIES_RESET;
  logic [CFG_W-1:0]     shadow_bytes = CFG_BYTES_RESET;
  logic [ADDR_W-1:0]    ring_addr[8];
  logic [IN_DATA_W-1:0] ring_data[8];
  int unsigned          ring_len[8];
  int unsigned          wr_slot = 0;
  int unsigned          rd_slot = 0;
  int unsigned          held_entries = 0;

  function automatic int unsigned ring_entries();
    if (shadow_entries < 1) return 1;
    if (shadow_entries > 8) return 8;
    return shadow_entries;
  endfunction

  function automatic int unsigned chunk_max();
    if (shadow_bytes < 1) return 1;
    if (shadow_bytes > 8) return 8;
    return shadow_bytes;
  endfunction

  function automatic int unsigned advance_slot(int unsigned p);
    return (p + 1 >= ring_entries()) ? 0 : p + 1;
  endfunction

  // Emit the oldest entry as byte writes and release it
  function automatic void flush_oldest();
    result_t          wr;
    logic [ADDR_W-1:0] addr;
    addr = ring_addr[rd_slot];
    for (int i = 0; i < ring_len[rd_slot]; i++) begin
      wr.mem_address = addr;
      wr.mem_byte    = ring_data[rd_slot][8*i +: 8];
      wr.last_of_run = 1'b0;
      expected_writes.push_back(wr);
      addr = addr + 1;
    end
    rd_slot = advance_slot(rd_slot);
    if (held_entries > 0) held_entries--;
  endfunction

  // Work out the memory writes that one accepted transfer causes
  function automatic void predict_transfer(item_t it);
    int                   base;
    logic [ADDR_W-1:0]    addr;
    logic [IN_DATA_W-1:0] data;
    int unsigned          left;
    int unsigned          take;
    base = expected_writes.size();
    if (it.kind == KIND_DRAIN) begin
      while (held_entries > 0) flush_oldest();
    end else begin
      addr = it.addr;
      data = it.data;
      left = (it.count > 8) ? 8 : it.count;
      while (left > 0) begin
        take = (left < chunk_max()) ? left : chunk_max();
        if (held_entries >= ring_entries()) flush_oldest();
        ring_addr[wr_slot] = addr;
        ring_len[wr_slot]  = take;
        ring_data[wr_slot] = (take >= 8) ? data : data & ((64'd1 << (8 * take)) - 64'd1);
        addr = addr + take;
        data = (take >= 8) ? '0 : data >> (8 * take);
        left = left - take;
        wr_slot = advance_slot(wr_slot);
        if (held_entries < 8) held_entries++;
      end
    end
    if (expected_writes.size() > base)
      expected_writes[expected_writes.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void queue_item(item_kind_t kind, logic [ADDR_W-1:0] addr,
                                     logic [IN_DATA_W-1:0] data, logic [COUNT_W-1:0] count);
    item_t it;
    it.kind  = kind;
    it.addr  = addr;
    it.data  = data;
    it.count = count;
    pending_items.push_back(it);
  endfunction

  // Input driver: hold an offered item while full, idle in random bursts
  always @(posedge clk) begin : input_driver
    bit accepted;
    int tx_gap;
    if (!rst_n) begin
      in_push <= 1'b0;
      tx_gap = 0;
    end else begin
      accepted = in_push && !in_full;
      if (accepted) predict_transfer(pending_items.pop_front());
      if (in_push && !accepted) begin
        // hold the current item until the block takes it
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_push <= 1'b0;
      end else if (tx_idle_en && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 18);
        in_push <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_push       <= 1'b1;
        in_opcode     <= pending_items[0].kind;
        in_address    <= pending_items[0].addr;
        in_data_bytes <= pending_items[0].data;
        in_byte_count <= pending_items[0].count;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Result monitor: check each transfer against the oldest expected write
  always @(posedge clk) begin : result_monitor
    result_t want;
    int      rx_gap;
    int      rx_hold_cnt;
    if (!rst_n) begin
      out_pop <= 1'b0;
      rx_gap = 0;
      rx_hold_cnt = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_writes.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] unexpected write: addr %h byte %h last %b", $realtime,
                     out_mem_address, out_mem_byte, out_last_of_run);
        end else begin
          want = expected_writes.pop_front();
          if (out_mem_address !== want.mem_address || out_mem_byte !== want.mem_byte ||
              out_last_of_run !== want.last_of_run) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("[%0t] write differs: expected addr %h byte %h last %b, got %h %h %b",
                       $realtime, want.mem_address, want.mem_byte, want.last_of_run,
                       out_mem_address, out_mem_byte, out_last_of_run);
          end
        end
      end
      if (rx_hold_req > 0) begin
        rx_hold_cnt = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold_cnt > 0) begin
        rx_hold_cnt--;
        out_pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_pop <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 18);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Wait until every queued item went in and every expected write came out
  task automatic wait_idle();
    do @(posedge clk); while (pending_items.size() != 0 || expected_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ENTRIES_IN_USE: shadow_entries = val;
      CFG_ENTRY_BYTES:    shadow_bytes = val;
      default: ;
    endcase
  endtask

  // One setting: configure, send random items, then drain so the ring is empty
  task automatic run_phase(input logic [CFG_W-1:0] entries, input logic [CFG_W-1:0] bytes,
                           input int n_items, input bit idle_on, input bit rx_hold);
    item_kind_t  kind;
    int unsigned pick;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    write_reg(CFG_ENTRIES_IN_USE, entries);
    write_reg(CFG_ENTRY_BYTES, bytes);
    tx_idle_en = idle_on;
    rx_idle_en = idle_on;
    if (rx_hold) rx_hold_req = RX_HOLD_LEN;
    repeat (n_items) begin
      kind = ($urandom_range(0, 99) < 8) ? KIND_DRAIN : KIND_WRITE;
      if ($urandom_range(0, 7) == 0) addr = 32'hFFFF_FFF8 + $urandom_range(0, 7);
      else addr = $urandom;
      pick = $urandom_range(0, 19);
      if (pick == 0) count = 4'd0;
      else if (pick == 1) count = COUNT_W'($urandom_range(9, 15));
      else if (rx_hold) count = 4'd8;
      else count = COUNT_W'($urandom_range(1, 8));
      queue_item(kind, addr, {$urandom, $urandom}, count);
    end
    queue_item(KIND_DRAIN, $urandom, {$urandom, $urandom}, COUNT_W'($urandom_range(0, 15)));
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset sizes: wrap, empty and oversized writes, drains
    queue_item(KIND_WRITE, 32'h0000_0000, {64{1'b1}}, 4'd8);
    queue_item(KIND_WRITE, 32'hFFFF_FFFF, 64'h0, 4'd8);
    queue_item(KIND_WRITE, 32'hFFFF_FFFF, {64{1'b1}}, 4'd0);
    queue_item(KIND_WRITE, 32'h0000_1000, 64'hAAAA_AAAA_AAAA_AAAA, 4'd15);
    queue_item(KIND_WRITE, 32'h0000_2000, 64'h5555_5555_5555_5555, 4'd1);
    queue_item(KIND_WRITE, 32'hFFFF_FFFD, 64'h0123_4567_89AB_CDEF, 4'd5);
    queue_item(KIND_DRAIN, 32'hFFFF_FFFF, {64{1'b1}}, 4'd15);
    queue_item(KIND_DRAIN, 32'h0, 64'h0, 4'd0);
    // fill the ring past its size to force an eviction
    for (int i = 0; i < 9; i++)
      queue_item(KIND_WRITE, 32'h8000_0000 + 16 * i, {$urandom, $urandom}, 4'd8);
    queue_item(KIND_DRAIN, 32'h0, 64'h0, 4'd0);
    wait_idle();

    // Settings, extremes and out-of-range values among them
    run_phase(4'd1,  4'd1,  20, 1'b1, 1'b0);
    run_phase(4'd0,  4'd0,  15, 1'b1, 1'b0);
    run_phase(4'd15, 4'd15, 15, 1'b1, 1'b0);
    run_phase(4'd8,  4'd8,  30, 1'b1, 1'b1);
    run_phase(4'd3,  4'd5,  20, 1'b1, 1'b0);
    run_phase(4'd9,  4'd2,  15, 1'b1, 1'b0);
    run_phase(4'd2,  4'd8,  15, 1'b1, 1'b0);
    run_phase(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)), 20, 1'b0, 1'b0);

    if (expected_writes.size() != 0) begin
      mismatch_cnt += expected_writes.size();
      $display("%0d expected writes never arrived", expected_writes.size());
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
src/wbf_pkg.sv
src/wbf_front.sv
src/wbf_outq.sv
src/wbf_back.sv
src/write_buffer_fifo.sv
sim/tb_write_buffer_fifo.sv
